/* rtl/core/bcq_pkg.sv */
// bcq_pkg: shared types and constants of the bumper collision qualifier.
// No dependencies; used by bcq_cfg_regs, bcq_qual_core and the top level.
`timescale 1ns / 1ps

package bcq_pkg;

    // Field widths fixed by the frame and register formats.
    localparam int FRAME_TIME_W = 32;
    localparam int INTERVAL_W   = 16;
    localparam int REPEAT_W     = 8;
    localparam int LIMIT_W      = INTERVAL_W + REPEAT_W;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic
    {
        REG_RELEASE_INTERVAL = 1'b0,
        REG_REPEAT_COUNT     = 1'b1
    } bcq_reg_idx_t;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);
    localparam logic [REPEAT_W-1:0]   REPEAT_RESET   = REPEAT_W'(3);
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = LIMIT_W'(300);

    // One frame as it enters the qualifier core.
    typedef struct packed
    {
        logic [FRAME_TIME_W-1:0] frame_time_ms;
        logic                    left_outer_pressed;
        logic                    left_inner_pressed;
        logic                    right_inner_pressed;
        logic                    right_outer_pressed;
    } bcq_frame_t;

    // One result beat.
    typedef struct packed
    {
        logic left_colliding;
        logic right_colliding;
        logic left_collision_event;
        logic right_collision_event;
    } bcq_result_t;

    // Thresholds handed from the register file to the core.
    typedef struct packed
    {
        logic [INTERVAL_W-1:0] interval;
        logic [LIMIT_W-1:0]    limit;
    } bcq_thresh_t;

endpackage

/* rtl/core/bcq_cfg_regs.sv */
// bcq_cfg_regs: APB register file for release interval and repeat count.
// Keeps the product of the two as a ready threshold. Depends on bcq_pkg.
`timescale 1ns / 1ps

module bcq_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcq_pkg::PADDR_W-1:0]   paddr,
    input  logic [bcq_pkg::PDATA_W-1:0]   pwdata,
    output logic [bcq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output bcq_pkg::bcq_thresh_t          thresh
);

    logic [bcq_pkg::INTERVAL_W-1:0] interval_reg, interval_next;
    logic [bcq_pkg::REPEAT_W-1:0]   repeat_reg, repeat_next;
    logic [bcq_pkg::LIMIT_W-1:0]    limit_reg, limit_next;
    logic                           wr_en;
    bcq_pkg::bcq_reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = bcq_pkg::bcq_reg_idx_t'(paddr[2]);

    // Update the product together with the operand being written.
    always_comb
    begin
        interval_next = interval_reg;
        repeat_next   = repeat_reg;
        limit_next    = limit_reg;
        if (wr_en)
        begin
            unique case (idx)
                bcq_pkg::REG_RELEASE_INTERVAL:
                begin
                    interval_next = pwdata[bcq_pkg::INTERVAL_W-1:0];
                    limit_next    = bcq_pkg::LIMIT_W'(pwdata[bcq_pkg::INTERVAL_W-1:0]) *
                                    bcq_pkg::LIMIT_W'(repeat_reg);
                end
                bcq_pkg::REG_REPEAT_COUNT:
                begin
                    repeat_next = pwdata[bcq_pkg::REPEAT_W-1:0];
                    limit_next  = bcq_pkg::LIMIT_W'(interval_reg) *
                                  bcq_pkg::LIMIT_W'(pwdata[bcq_pkg::REPEAT_W-1:0]);
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= bcq_pkg::INTERVAL_RESET;
            repeat_reg   <= bcq_pkg::REPEAT_RESET;
            limit_reg    <= bcq_pkg::LIMIT_RESET;
        end
        else
        begin
            interval_reg <= interval_next;
            repeat_reg   <= repeat_next;
            limit_reg    <= limit_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            bcq_pkg::REG_RELEASE_INTERVAL:
                prdata = bcq_pkg::PDATA_W'(interval_reg);
            bcq_pkg::REG_REPEAT_COUNT:
                prdata = bcq_pkg::PDATA_W'(repeat_reg);
            default:
                prdata = '0;
        endcase
    end

    assign thresh.interval = interval_reg;
    assign thresh.limit    = limit_reg;

endmodule

/* rtl/core/bcq_qual_core.sv */
// bcq_qual_core: per-foot collision state and the one-frame qualify logic.
// Depends on bcq_pkg; thresholds come from bcq_cfg_regs.
`timescale 1ns / 1ps

module bcq_qual_core
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 update,
    input  bcq_pkg::bcq_frame_t  frame,
    input  bcq_pkg::bcq_thresh_t thresh,
    output bcq_pkg::bcq_result_t result
);

    localparam int EXT_W = (TIME_BITS > bcq_pkg::FRAME_TIME_W) ?
                           TIME_BITS : bcq_pkg::FRAME_TIME_W;
    localparam int CMP_W = (TIME_BITS > bcq_pkg::LIMIT_W) ? TIME_BITS : bcq_pkg::LIMIT_W;

    logic                 l_flag_reg, l_flag_next, r_flag_reg, r_flag_next;
    logic [TIME_BITS-1:0] l_last_reg, l_last_next, r_last_reg, r_last_next;
    logic [TIME_BITS-1:0] l_start_reg, l_start_next, r_start_reg, r_start_next;

    logic [EXT_W-1:0]     time_ext;
    logic [TIME_BITS-1:0] now;
    logic                 lp, rp;
    logic [TIME_BITS-1:0] l_rel_age, r_rel_age, l_run_age, r_run_age;
    logic                 l_drop, r_drop, l_keep, r_keep, rise, l_rose, r_rose;
    logic                 l_up, r_up, l_ev, r_ev;

    assign time_ext = EXT_W'(frame.frame_time_ms);
    assign now      = time_ext[TIME_BITS-1:0];
    assign lp       = frame.left_outer_pressed | frame.left_inner_pressed;
    assign rp       = frame.right_inner_pressed | frame.right_outer_pressed;

    // Release ages: a pressed foot has age zero, so only the stored time matters.
    assign l_rel_age = now - l_last_reg;
    assign r_rel_age = now - r_last_reg;
    // Run ages against the stored start; a start set this frame never fires.
    assign l_run_age = now - l_start_reg;
    assign r_run_age = now - r_start_reg;

    assign l_drop = l_flag_reg & ~lp &
                    (CMP_W'(l_rel_age) > CMP_W'(thresh.interval));
    assign r_drop = r_flag_reg & ~rp &
                    (CMP_W'(r_rel_age) > CMP_W'(thresh.interval));
    assign l_keep = l_flag_reg & ~l_drop;
    assign r_keep = r_flag_reg & ~r_drop;

    assign rise   = ~l_keep & ~r_keep;
    assign l_rose = rise & lp;
    assign r_rose = rise & rp;
    assign l_up   = l_keep | l_rose;
    assign r_up   = r_keep | r_rose;

    assign l_ev = l_keep & (CMP_W'(l_run_age) > CMP_W'(thresh.limit));
    assign r_ev = r_keep & (CMP_W'(r_run_age) > CMP_W'(thresh.limit));

    always_comb
    begin
        l_flag_next  = l_up & ~l_ev;
        r_flag_next  = r_up & ~r_ev;
        l_last_next  = lp ? now : l_last_reg;
        r_last_next  = rp ? now : r_last_reg;
        l_start_next = (l_drop | l_rose | l_ev) ? now : l_start_reg;
        r_start_next = (r_drop | r_rose | r_ev) ? now : r_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_flag_reg  <= 1'b0;
            r_flag_reg  <= 1'b0;
            l_last_reg  <= '0;
            r_last_reg  <= '0;
            l_start_reg <= '0;
            r_start_reg <= '0;
        end
        else if (update)
        begin
            l_flag_reg  <= l_flag_next;
            r_flag_reg  <= r_flag_next;
            l_last_reg  <= l_last_next;
            r_last_reg  <= r_last_next;
            l_start_reg <= l_start_next;
            r_start_reg <= r_start_next;
        end
    end

    assign result.left_colliding        = l_flag_next;
    assign result.right_colliding       = r_flag_next;
    assign result.left_collision_event  = l_ev;
    assign result.right_collision_event = r_ev;

endmodule

/* rtl/core/bumper_collision_qualifier.sv */
// bumper_collision_qualifier: top level, frame input register, core and result register.
// Depends on bcq_pkg, bcq_cfg_regs and bcq_qual_core.
`timescale 1ns / 1ps

//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  frame   | frame_valid / frame_stall  | frame_time_ms, four *_pressed bits
//  result  | result_valid/ result_stall | left/right_colliding, left/right_*_event
//  config  | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  One frame beat is taken per cycle while frame_stall is low. A beat lands in the
//  input register, the core qualifies it combinationally and the result register
//  loads it once that register can take a beat, which raises result_valid. The
//  loop that sets the rate is the per-foot state update inside the core.
//  Reset clears both flags, the press and start times and loads the register
//  defaults (interval 100, repeat count 3). A stalled result holds its beat;
//  the input register can still take one frame behind it, then frame_stall rises.

module bumper_collision_qualifier
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // frame channel
    input  logic                                frame_valid,
    output logic                                frame_stall,
    input  logic [bcq_pkg::FRAME_TIME_W-1:0]    frame_time_ms,
    input  logic                                left_outer_pressed,
    input  logic                                left_inner_pressed,
    input  logic                                right_inner_pressed,
    input  logic                                right_outer_pressed,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                left_colliding,
    output logic                                right_colliding,
    output logic                                left_collision_event,
    output logic                                right_collision_event,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bcq_pkg::PADDR_W-1:0]         paddr,
    input  logic [bcq_pkg::PDATA_W-1:0]         pwdata,
    output logic [bcq_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    bcq_pkg::bcq_thresh_t thresh;
    bcq_pkg::bcq_frame_t  frame_reg, frame_next;
    bcq_pkg::bcq_result_t result_reg, result_next;
    logic                 in_valid_reg, in_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 frame_take;
    logic                 advance;
    logic                 move;

    // Register file with the precomputed event threshold.
    bcq_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thresh  (thresh)
    );

    // The result register can load when empty or when its beat leaves now.
    assign advance     = ~out_valid_reg | ~result_stall;
    assign move        = in_valid_reg & advance;
    assign frame_stall = in_valid_reg & ~advance;
    assign frame_take  = frame_valid & ~frame_stall;

    always_comb
    begin
        frame_next.frame_time_ms       = frame_time_ms;
        frame_next.left_outer_pressed  = left_outer_pressed;
        frame_next.left_inner_pressed  = left_inner_pressed;
        frame_next.right_inner_pressed = right_inner_pressed;
        frame_next.right_outer_pressed = right_outer_pressed;
    end

    // Input register: fill on take, drain on move, hold otherwise.
    always_comb
    begin
        if (frame_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // Qualify the registered frame and advance the foot state when it moves.
    bcq_qual_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (move),
        .frame  (frame_reg),
        .thresh (thresh),
        .result (result_next)
    );

    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            frame_reg <= frame_next;
        end
        if (move)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid          = out_valid_reg;
    assign left_colliding        = result_reg.left_colliding;
    assign right_colliding       = result_reg.right_colliding;
    assign left_collision_event  = result_reg.left_collision_event;
    assign right_collision_event = result_reg.right_collision_event;

endmodule

/* rtl/core/bcq_checker.sv */
// bcq_checker: port-level assertions for bumper_collision_qualifier, and its bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module bcq_checker
(
    input logic clk,
    input logic rst_n,
    input logic frame_valid,
    input logic frame_stall,
    input logic result_valid,
    input logic result_stall,
    input logic left_colliding,
    input logic right_colliding,
    input logic left_collision_event,
    input logic right_collision_event
);

    // A stalled result beat holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid &&
        $stable({left_colliding, right_colliding,
                 left_collision_event, right_collision_event}))
        else $error("stalled result beat changed");

    // A confirmed collision clears its flag in the same beat.
    a_left_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && left_collision_event |-> !left_colliding)
        else $error("left event with left flag still up");

    a_right_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && right_collision_event |-> !right_colliding)
        else $error("right event with right flag still up");

    // A frame taken behind a stalled result fills the input register.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall && frame_valid && !frame_stall
        |=> (!result_stall || frame_stall))
        else $error("frame taken with both stages full");

endmodule

bind bumper_collision_qualifier bcq_checker u_bcq_checker
(
    .clk                   (clk),
    .rst_n                 (rst_n),
    .frame_valid           (frame_valid),
    .frame_stall           (frame_stall),
    .result_valid          (result_valid),
    .result_stall          (result_stall),
    .left_colliding        (left_colliding),
    .right_colliding       (right_colliding),
    .left_collision_event  (left_collision_event),
    .right_collision_event (right_collision_event)
);
